### design/fcgl_pkg.sv
// shared types and constants for the character-map glyph lookup
`default_nettype none

package fcgl_pkg;

    // item function codes
    localparam logic [1:0] FUNC_SEG_WR  = 2'd0;
    localparam logic [1:0] FUNC_WORD_WR = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP  = 2'd2;

    // configuration register indexes
    localparam logic CFG_MAP_FORMAT = 1'b0;
    localparam logic CFG_SEG_COUNT  = 1'b1;

    // format 4 word start that marks a delta-only segment
    localparam logic [15:0] DELTA_ONLY = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] slot;
        logic [20:0] code;
        logic [20:0] end_code;
        logic [31:0] seg_value;
        logic [15:0] offset_start;
        logic [15:0] word;
    } t_in;

    typedef struct packed {
        logic [31:0] glyph_index;
        logic        present;
    } t_out;

    typedef struct packed {
        logic        valid;
        t_out        data;
    } t_res;

    typedef struct packed {
        logic [20:0] seg_start;
        logic [20:0] seg_end;
        logic [31:0] seg_param;
        logic [15:0] word_start;
    } t_seg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_WORD,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### design/font_charmap_glyph_lookup_top.sv
// top level of the character-map glyph lookup: config registers and output register
// a lookup passes through start, the search probes, a word-store read after a hit that needs one,
// and done, from accept to the result register; an empty table goes straight from start to done
// loads (segment or word writes) give no result
// one lookup at a time; the next transfer is taken in the cycle after the result is parked
// reset (synchronous, active low) clears the sequencer, the output valid and the
// config registers; the stores are not cleared and hold garbage until written
`default_nettype none

module font_charmap_glyph_lookup_top #(
    parameter int MAX_SEGMENTS = 256,
    parameter int MAX_WORDS    = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // item input
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire fcgl_pkg::t_in i_in_data,
    // result output
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output fcgl_pkg::t_out     o_out_data,
    // configuration writes
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [8:0]    i_cfg_wdata
);

    // count width holds 0 .. MAX_SEGMENTS
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    logic           r_map_format;
    logic [8:0]     r_segment_count;
    logic [CW-1:0]  seg_count_eff;
    logic           r_out_valid;
    fcgl_pkg::t_out r_out_data;
    logic           out_free;
    fcgl_pkg::t_res res;

    // config registers, to be written only while idle; the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_format    <= 1'b0;
            r_segment_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fcgl_pkg::CFG_MAP_FORMAT: r_map_format    <= i_cfg_wdata[0];
                fcgl_pkg::CFG_SEG_COUNT:  r_segment_count <= i_cfg_wdata;
                default:                  r_map_format    <= r_map_format;
            endcase
        end
    end

    // a count above the store depth saturates
    assign seg_count_eff = (32'(r_segment_count) > 32'(MAX_SEGMENTS))
                           ? CW'(MAX_SEGMENTS) : CW'(r_segment_count);

    fcgl_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_WORDS    (MAX_WORDS),
        .CW           (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_ready   (o_in_ready),
        .i_map_format (r_map_format),
        .i_seg_count  (seg_count_eff),
        .i_out_free   (out_free),
        .o_res        (res)
    );

    // output register frees the sequencer as soon as a result is parked
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res.valid) begin
            r_out_data <= res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### design/fcgl_ram.sv
// simple dual-port memory with registered read data
`default_nettype none

module fcgl_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/fcgl_ctrl.sv
// search sequencer: binary search over the segment store and glyph mapping
`default_nettype none

module fcgl_ctrl #(
    parameter int MAX_SEGMENTS = 256,
    parameter int MAX_WORDS    = 4096,
    parameter int CW           = $clog2(MAX_SEGMENTS + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire fcgl_pkg::t_in   i_in_data,
    output logic                 o_in_ready,
    input  wire logic            i_map_format,
    input  wire logic [CW-1:0]   i_seg_count,
    input  wire logic            i_out_free,
    output fcgl_pkg::t_res       o_res
);

    localparam int SAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int WAW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int SEG_W = $bits(fcgl_pkg::t_seg);

    fcgl_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi1, n_hi1;
    logic [CW-1:0]    r_mid, n_mid;
    logic [20:0]      r_code, n_code;
    logic [31:0]      r_glyph, n_glyph;
    logic [15:0]      r_delta, n_delta;

    logic             in_acc;
    logic             res_valid;
    logic [31:0]      slot32;
    logic             seg_we, seg_re;
    logic             word_we, word_re;
    logic [SEG_W-1:0] seg_rraw;
    fcgl_pkg::t_seg   seg_wdata, seg_rd;
    logic [15:0]      word_rd;

    logic             gt, lt;
    logic [CW-1:0]    mid_p1, s_lo, s_hi1, s_mid;
    logic [CW:0]      s_sum;
    logic             s_more;
    logic [31:0]      mid32, widx32;
    logic [20:0]      rel;
    logic [21:0]      widx;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == fcgl_pkg::ST_IDLE);
    assign slot32     = 32'(i_in_data.slot);

    // loads go straight to the stores on the accepting edge
    assign seg_we  = in_acc && (i_in_data.func == fcgl_pkg::FUNC_SEG_WR)
                     && (slot32 < 32'(MAX_SEGMENTS));
    assign word_we = in_acc && (i_in_data.func == fcgl_pkg::FUNC_WORD_WR)
                     && (slot32 < 32'(MAX_WORDS));

    assign seg_wdata.seg_start  = i_in_data.code;
    assign seg_wdata.seg_end    = i_in_data.end_code;
    assign seg_wdata.seg_param  = i_in_data.seg_value;
    assign seg_wdata.word_start = i_in_data.offset_start;

    assign seg_rd = seg_rraw;

    // probe compare and next bounds (hi1 is the upper bound plus one)
    assign gt     = (r_code > seg_rd.seg_end);
    assign lt     = (r_code < seg_rd.seg_start);
    assign mid_p1 = r_mid + CW'(1);
    assign s_lo   = (r_state == fcgl_pkg::ST_SEARCH && gt) ? mid_p1 : r_lo;
    assign s_hi1  = (r_state == fcgl_pkg::ST_SEARCH && !gt && lt) ? r_mid : r_hi1;
    assign s_more = (s_lo < s_hi1);
    assign s_sum  = {1'b0, s_lo} + {1'b0, s_hi1} - (CW+1)'(1);
    assign s_mid  = s_sum[CW:1];
    assign mid32  = 32'(s_mid);

    assign rel    = r_code - seg_rd.seg_start;
    assign widx   = {6'b0, seg_rd.word_start} + {1'b0, rel};
    assign widx32 = 32'(widx);

    fcgl_ram #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (SEG_W)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (seg_we),
        .i_waddr (slot32[SAW-1:0]),
        .i_wdata (seg_wdata),
        .i_re    (seg_re),
        .i_raddr (mid32[SAW-1:0]),
        .o_rdata (seg_rraw)
    );

    fcgl_ram #(
        .DEPTH (MAX_WORDS),
        .WIDTH (16)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (word_we),
        .i_waddr (slot32[WAW-1:0]),
        .i_wdata (i_in_data.word),
        .i_re    (word_re),
        .i_raddr (widx32[WAW-1:0]),
        .o_rdata (word_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcgl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi1   <= n_hi1;
        r_mid   <= n_mid;
        r_code  <= n_code;
        r_glyph <= n_glyph;
        r_delta <= n_delta;
    end

    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi1     = r_hi1;
        n_mid     = r_mid;
        n_code    = r_code;
        n_glyph   = r_glyph;
        n_delta   = r_delta;
        seg_re    = 1'b0;
        word_re   = 1'b0;
        res_valid = 1'b0;
        unique case (r_state)
            fcgl_pkg::ST_IDLE: begin
                if (in_acc && i_in_data.func == fcgl_pkg::FUNC_LOOKUP) begin
                    n_code  = i_in_data.code;
                    n_lo    = '0;
                    n_hi1   = i_seg_count;
                    n_state = fcgl_pkg::ST_START;
                end
            end
            fcgl_pkg::ST_START, fcgl_pkg::ST_SEARCH: begin
                if (r_state == fcgl_pkg::ST_SEARCH && !gt && !lt) begin
                    // hit
                    n_state = fcgl_pkg::ST_DONE;
                    if (i_map_format) begin
                        n_glyph = seg_rd.seg_param + 32'(rel);
                    end else if (seg_rd.word_start == fcgl_pkg::DELTA_ONLY) begin
                        n_glyph = {16'b0, r_code[15:0] + seg_rd.seg_param[15:0]};
                    end else if (widx32 < 32'(MAX_WORDS)) begin
                        word_re = 1'b1;
                        n_delta = seg_rd.seg_param[15:0];
                        n_state = fcgl_pkg::ST_WORD;
                    end else begin
                        n_glyph = '0;
                    end
                end else begin
                    n_lo  = s_lo;
                    n_hi1 = s_hi1;
                    if (s_more) begin
                        seg_re  = 1'b1;
                        n_mid   = s_mid;
                        n_state = fcgl_pkg::ST_SEARCH;
                    end else begin
                        n_glyph = '0;
                        n_state = fcgl_pkg::ST_DONE;
                    end
                end
            end
            fcgl_pkg::ST_WORD: begin
                n_glyph = (word_rd == 16'd0) ? 32'd0 : {16'b0, word_rd + r_delta};
                n_state = fcgl_pkg::ST_DONE;
            end
            fcgl_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (i_out_free) begin
                    n_state = fcgl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fcgl_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res.valid            = res_valid;
    assign o_res.data.glyph_index = r_glyph;
    assign o_res.data.present     = (r_glyph != 32'd0);

`ifndef SYNTHESIS
    a_no_seg_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(seg_we && seg_re))
        else $error("segment store read and written in one cycle");

    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcgl_pkg::ST_SEARCH) |-> (r_lo < r_hi1 && r_hi1 <= i_seg_count))
        else $error("search bounds out of order");

    a_word_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcgl_pkg::ST_WORD) |-> ($past(r_state) == fcgl_pkg::ST_SEARCH))
        else $error("word read without a segment hit");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (word_re || seg_re) |-> !o_in_ready)
        else $error("store read while taking items");
`endif

endmodule

`default_nettype wire
